// ===== rtl/dls_pkg.sv =====
package dls_pkg;

  // Fixed sizes of the delimiter and the hold window
  localparam int DELIM_MAX  = 8;
  localparam int HOLD_DEPTH = DELIM_MAX - 1;
  localparam int LEN_W      = 4;
  localparam int HOLD_W     = 3;
  localparam int IDX_W      = 3;

  typedef logic [7:0] byte_t;

  // Input operation codes
  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_DELIM_LEN   = 2'd0,
    CFG_DELIM_BYTES = 2'd1,
    CFG_KEEP_DELIM  = 2'd2
  } cfg_idx_t;

  // One job handed from the front to the back.
  // hist[0] is the newest byte, hist[top] the oldest one emitted first.
  typedef struct packed {
    logic [DELIM_MAX-1:0][7:0] hist;
    logic [IDX_W-1:0]          top;
    logic [LEN_W-1:0]          nbytes;
    logic                      bare_eol;
    logic                      eol_last;
  } job_t;

endpackage

// ===== rtl/dls_if.sv =====
// Input channel: one byte push or a flush per item
interface dls_in_if;
  import dls_pkg::*;
  logic  valid;
  logic  ready;
  op_t   operation;
  byte_t in_byte;

  modport source (output valid, operation, in_byte, input ready);
  modport sink   (input valid, operation, in_byte, output ready);
endinterface

// Output channel: one result item per handshake
interface dls_out_if;
  import dls_pkg::*;
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  has_byte;
  logic  end_of_line;
  logic  last_of_run;

  modport source (output valid, out_byte, has_byte, end_of_line, last_of_run, input ready);
  modport sink   (input valid, out_byte, has_byte, end_of_line, last_of_run, output ready);
endinterface

// Configuration write channel
interface dls_cfg_if;
  import dls_pkg::*;
  logic        valid;
  logic        ready;
  cfg_idx_t    index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/dls_front.sv =====
module dls_front (
  input  logic         clk,
  input  logic         rst,
  dls_in_if.sink       in_ch,
  dls_cfg_if.sink      cfg_ch,
  input  logic         q_full,
  output logic         push,
  output dls_pkg::job_t job
);
  import dls_pkg::*;

  logic [LEN_W-1:0]               delim_len;
  logic [63:0]                    delim_bytes;
  logic                           keep_delim;
  logic [HOLD_DEPTH-1:0][7:0]     held;
  logic [HOLD_W-1:0]              hold_count;
  logic [HOLD_W-1:0]              hold_count_next;

  logic [DELIM_MAX-1:0][7:0]      hist;
  logic [LEN_W-1:0]               count;
  logic [LEN_W-1:0]               eff_len;
  logic [LEN_W-1:0]               keep_n;
  logic [LEN_W-1:0]               retained;
  logic [DELIM_MAX-1:0]           len_hit;
  logic                           match;
  logic                           accept;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_full;
  assign accept       = in_ch.valid && in_ch.ready;

  // Window with the new byte at the bottom, newest first
  assign hist    = {held, in_ch.in_byte};
  assign count   = {1'b0, hold_count} + LEN_W'(1);
  assign eff_len = (delim_len > LEN_W'(DELIM_MAX)) ? LEN_W'(DELIM_MAX) : delim_len;
  assign keep_n  = (eff_len == '0) ? '0 : eff_len - LEN_W'(1);
  assign retained = (count < keep_n) ? count : keep_n;

  // Compare the tail of the window against every delimiter length at once
  always_comb begin
    for (int l = 1; l <= DELIM_MAX; l++) begin
      len_hit[l-1] = 1'b1;
      for (int i = 0; i < l; i++) begin
        if (hist[l-1-i] != delim_bytes[8*i +: 8]) len_hit[l-1] = 1'b0;
      end
    end
  end

  assign match = (eff_len != '0) && (count >= eff_len) &&
                 len_hit[IDX_W'(eff_len - LEN_W'(1))];

  // Classify the item into a job and the next hold count
  always_comb begin
    job.hist        = hist;
    job.top         = hold_count;
    job.nbytes      = '0;
    job.bare_eol    = 1'b0;
    job.eol_last    = 1'b0;
    hold_count_next = hold_count;
    unique case (in_ch.operation)
      OP_FLUSH: begin
        job.nbytes      = {1'b0, hold_count};
        hold_count_next = '0;
      end
      OP_PUSH: begin
        if (match) begin
          job.nbytes      = keep_delim ? count : count - eff_len;
          job.bare_eol    = !keep_delim;
          job.eol_last    = keep_delim;
          hold_count_next = '0;
        end else begin
          job.nbytes      = count - retained;
          hold_count_next = retained[HOLD_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign push = accept && ((job.nbytes != '0) || job.bare_eol);

  // Hold window state
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count <= '0;
    end else if (accept) begin
      hold_count <= hold_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.operation == OP_PUSH) begin
      held <= hist[HOLD_DEPTH-1:0];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      delim_len   <= LEN_W'(1);
      delim_bytes <= 64'd10;
      keep_delim  <= 1'b0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        CFG_DELIM_LEN:   delim_len   <= cfg_ch.data[LEN_W-1:0];
        CFG_DELIM_BYTES: delim_bytes <= cfg_ch.data;
        CFG_KEEP_DELIM:  keep_delim  <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/dls_queue.sv =====
module dls_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dls_pkg::job_t wr_job,
  input  logic          pop,
  output dls_pkg::job_t head,
  output logic          full,
  output logic          empty
);
  import dls_pkg::*;

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full  = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign head  = mem[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop)      fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_job;
  end

endmodule

// ===== rtl/dls_back.sv =====
module dls_back (
  input  logic          clk,
  input  logic          rst,
  input  dls_pkg::job_t head,
  input  logic          q_empty,
  output logic          pop,
  dls_out_if.source     out_ch
);
  import dls_pkg::*;

  logic [LEN_W-1:0] ridx;
  logic [LEN_W-1:0] total;
  logic             advance;
  logic             take;
  logic             is_last;
  logic             in_data;

  assign total   = head.nbytes + {{(LEN_W-1){1'b0}}, head.bare_eol};
  assign is_last = (ridx == total - LEN_W'(1));
  assign in_data = (ridx < head.nbytes);
  assign advance = !out_ch.valid || out_ch.ready;
  assign take    = !q_empty && advance;
  assign pop     = take && is_last;

  // Output register valid and result index
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
      ridx         <= '0;
    end else begin
      if (take)              out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
      if (take) ridx <= is_last ? '0 : ridx + LEN_W'(1);
    end
  end

  // Result payload: oldest bytes first, then an optional bare end of line
  always_ff @(posedge clk) begin
    if (take) begin
      out_ch.last_of_run <= is_last;
      if (in_data) begin
        out_ch.out_byte    <= head.hist[head.top - ridx[IDX_W-1:0]];
        out_ch.has_byte    <= 1'b1;
        out_ch.end_of_line <= head.eol_last && (ridx == head.nbytes - LEN_W'(1));
      end else begin
        out_ch.out_byte    <= '0;
        out_ch.has_byte    <= 1'b0;
        out_ch.end_of_line <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/delimiter_line_splitter.sv =====
// Channel  Dir  Payload                                         Accepted when
// in_ch    in   operation, in_byte                              valid & ready
// out_ch   out  out_byte, has_byte, end_of_line, last_of_run    valid & ready
// cfg_ch   in   index, data                                     valid & ready (ready always 1)
//
// Rate: the front takes one item per cycle unless the job queue is full; the back
//   sends one result per cycle unless out_ch stalls; a job has 1 to 8 results.
// Path: an item with results becomes a queued job; the back registers each result.
// Stalls: in_ch.ready drops only when the two-entry job queue is full.
// Reset: rst is synchronous; it empties the hold window and the queue and loads
//   delimiter length 1, delimiter line feed, strip mode.
module delimiter_line_splitter (
  input logic       clk,
  input logic       rst,
  dls_in_if.sink    in_ch,
  dls_out_if.source out_ch,
  dls_cfg_if.sink   cfg_ch
);
  import dls_pkg::*;

  job_t front_job;
  job_t head_job;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  dls_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .push   (push),
    .job    (front_job)
  );

  dls_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (front_job),
    .pop    (pop),
    .head   (head_job),
    .full   (q_full),
    .empty  (q_empty)
  );

  dls_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head_job),
    .q_empty (q_empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );

`ifndef ASSERT_OFF
  // Queue cannot be full and empty together
  a_queue_level: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty))
    else $error("job queue full and empty at once");

  // A bare end of line always closes the run of its item
  a_bare_eol_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.has_byte |-> out_ch.end_of_line && out_ch.last_of_run)
    else $error("bare end of line not last of run");

  // A result without a byte carries a zero byte
  a_bare_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.has_byte |-> out_ch.out_byte == 8'd0)
    else $error("bare result carries a nonzero byte");

  // Nothing leaves the queue while it is empty
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_empty |-> !pop)
    else $error("pop from empty job queue");
`endif

endmodule
